// ----- sv/tlik_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tlik_pkg;

  localparam int CoordW  = 18;
  localparam int LinkW   = 8;
  localparam int SprW    = 12;
  localparam int ShW     = 16;
  localparam int ElW     = 14;
  localparam int StatW   = 2;
  localparam int AngW    = 34;   // 2^-30 rad, covers +-2*pi
  localparam int AtanLen = 24;
  localparam logic signed [AngW-1:0] PiQ30 = 34'sd3373259426;

  typedef enum logic [StatW-1:0] {
    ST_SOLVED = 2'd0,
    ST_REACH  = 2'd1,
    ST_ORIGIN = 2'd2
  } solve_status_t;

  typedef enum logic [1:0] {
    REG_UPPER = 2'd0,
    REG_LOWER = 2'd1,
    REG_SPR   = 2'd2
  } reg_index_t;

  function automatic logic signed [AngW-1:0] atan_q30(input int i);
    case (i)
      0: atan_q30 = 34'sd843314856;
      1: atan_q30 = 34'sd497837829;
      2: atan_q30 = 34'sd263043836;
      3: atan_q30 = 34'sd133525158;
      4: atan_q30 = 34'sd67021686;
      5: atan_q30 = 34'sd33543515;
      6: atan_q30 = 34'sd16775850;
      7: atan_q30 = 34'sd8388437;
      8: atan_q30 = 34'sd4194282;
      9: atan_q30 = 34'sd2097149;
      10: atan_q30 = 34'sd1048575;
      11: atan_q30 = 34'sd524287;
      12: atan_q30 = 34'sd262143;
      13: atan_q30 = 34'sd131071;
      14: atan_q30 = 34'sd65535;
      15: atan_q30 = 34'sd32767;
      16: atan_q30 = 34'sd16383;
      17: atan_q30 = 34'sd8191;
      18: atan_q30 = 34'sd4095;
      19: atan_q30 = 34'sd2047;
      20: atan_q30 = 34'sd1023;
      21: atan_q30 = 34'sd511;
      22: atan_q30 = 34'sd255;
      23: atan_q30 = 34'sd127;
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- sv/tlik_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface tlik_target_if;
  logic valid;
  logic ready;
  logic signed [17:0] target_x;
  logic signed [17:0] target_y;
  modport source (output valid, target_x, target_y, input ready);
  modport sink (input valid, target_x, target_y, output ready);
endinterface

interface tlik_joint_if;
  logic valid;
  logic ready;
  logic signed [15:0] shoulder_steps;
  logic [13:0] elbow_steps;
  logic [1:0] solve_status;
  modport source (output valid, shoulder_steps, elbow_steps, solve_status, input ready);
  modport sink (input valid, shoulder_steps, elbow_steps, solve_status, output ready);
endinterface
`default_nettype wire

// ----- sv/two_link_inverse_kinematics_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Two-link planar inverse kinematics, fully pipelined: one target point per
// clock. ANGLE_ITERATIONS counts up to 24. The pipe is made of four front
// stages, one square root stage per root bit (COORD_FRAC_BITS + 9), the
// product stage, a prerotate stage plus one stage per CORDIC step, and three
// back stages. The whole pipe advances together and holds when the output
// register is full and not taken; target.ready follows joint.ready
// combinationally, so a stall reaches the input in the same cycle.
// Configuration writes (index 0 upper link, 1 lower link, 2 steps per radian)
// take effect at once and belong only while the pipe is empty.
module two_link_inverse_kinematics_core #(
  parameter int COORD_FRAC_BITS  = 8,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  tlik_target_if.sink      target,
  tlik_joint_if.source     joint,
  input  wire logic        cfg_write_enable,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_write_data
);
  import tlik_pkg::*;

  localparam int F    = COORD_FRAC_BITS;
  localparam int LW   = LinkW + F;            // link in coordinate units
  localparam int RRW  = 2 * CoordW;           // x^2 + y^2 width (unsigned)
  localparam int SQW  = 2 * (LW + 1);         // radicand width, even
  localparam int SW   = SQW;                  // product of two roots
  localparam int XW   = ((SW > RRW + 2) ? SW : RRW + 2) + 2;
  localparam int SQL  = SQW / 2;
  localparam int TW   = 1 + 2 + 2 * CoordW;   // valid, status, x, y

  // Configuration registers.
  logic [LinkW-1:0] upper_len, lower_len;
  logic [SprW-1:0]  spr;
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len <= LinkW'(75);
      lower_len <= LinkW'(75);
      spr       <= SprW'(326);
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_UPPER: upper_len <= cfg_write_data[LinkW-1:0];
        REG_LOWER: lower_len <= cfg_write_data[LinkW-1:0];
        REG_SPR:   spr       <= cfg_write_data;
        default: ;
      endcase
    end
  end

  // Whole pipe advances when its last stage can move on.
  logic en;
  logic out_valid, out_full;

  // Stage 1: squares.
  logic                     v1;
  logic signed [CoordW-1:0] x1, y1;
  logic [RRW-1:0]           xx1, yy1;
  logic [LW-1:0]            a1, b1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= target.valid;
    if (en) begin
      x1  <= target.target_x;
      y1  <= target.target_y;
      xx1 <= RRW'(target.target_x * target.target_x);
      yy1 <= RRW'(target.target_y * target.target_y);
      a1  <= LW'(upper_len) << F;
      b1  <= LW'(lower_len) << F;
    end
  end

  // Stage 2: rr, link difference and sum.
  logic                     v2;
  logic signed [CoordW-1:0] x2, y2;
  logic [RRW:0]             rr2;
  logic signed [LW+1:0]     dn2, dp2;
  logic [LW-1:0]            a2, b2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      x2  <= x1; y2 <= y1;
      rr2 <= (RRW+1)'(xx1) + (RRW+1)'(yy1);
      dn2 <= (LW+2)'(a1) - (LW+2)'(b1);
      dp2 <= (LW+2)'(a1) + (LW+2)'(b1);
      a2  <= a1; b2 <= b1;
    end
  end

  // Stage 3: squared bounds and link squares.
  localparam int DW = 2 * (LW + 1);
  logic                     v3;
  logic signed [CoordW-1:0] x3, y3;
  logic [RRW:0]             rr3;
  logic [DW-1:0]            dmin3, dmax3, aa3, bb3;
  logic                     zl3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      x3 <= x2; y3 <= y2; rr3 <= rr2;
      dmin3 <= DW'(dn2 * dn2);
      dmax3 <= DW'(dp2 * dp2);
      aa3   <= DW'(a2) * DW'(a2);
      bb3   <= DW'(b2) * DW'(b2);
      zl3   <= (a2 == '0) || (b2 == '0);
    end
  end

  // Stage 4: status, radicands, CORDIC x inputs.
  localparam int CW = (DW > RRW + 1 ? DW : RRW + 1) + 2;
  logic                     v4;
  logic [1:0]               st4;
  logic signed [CoordW-1:0] x4, y4;
  logic [SQW-1:0]           p4, q4;
  logic signed [XW-1:0]     cb4, cl4;
  logic signed [CW-1:0]     rrc, dminc, dmaxc, aac, bbc;
  always_comb begin
    rrc   = CW'(rr3);
    dminc = CW'(dmin3);
    dmaxc = CW'(dmax3);
    aac   = CW'(aa3);
    bbc   = CW'(bb3);
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      x4 <= x3; y4 <= y3;
      if (rr3 == '0) st4 <= ST_ORIGIN;
      else if (zl3 || rrc < dminc || rrc > dmaxc) st4 <= ST_REACH;
      else st4 <= ST_SOLVED;
      p4  <= SQW'(rrc - dminc);
      q4  <= SQW'(dmaxc - rrc);
      cb4 <= XW'(aac + bbc - rrc);
      cl4 <= XW'(aac - bbc + rrc);
    end
  end

  // Square roots, both in lockstep; the p root's tag carries the CORDIC x inputs.
  localparam int QT = 2 * XW + 1 + 2 + 2 * CoordW;
  logic [QT-1:0]  qtag_in, qtag_out;
  logic [SQL-1:0] rp5, rq5;
  logic           unused_tag;
  assign qtag_in = {cb4, cl4, v4, st4, x4, y4};
  tlik_isqrt #(.W(SQW), .TAG_W(QT)) u_sqrt_p (
    .clk, .rst, .en, .radicand(p4), .tag_in(qtag_in), .root(rp5), .tag_out(qtag_out));
  logic [QT-1:0] qtag_unused;
  tlik_isqrt #(.W(SQW), .TAG_W(1)) u_sqrt_q (
    .clk, .rst, .en, .radicand(q4), .tag_in(1'b0), .root(rq5), .tag_out(unused_tag));
  assign qtag_unused = qtag_out;

  logic signed [XW-1:0]     cb5, cl5;
  logic                     v5raw;
  logic [1:0]               st5;
  logic signed [CoordW-1:0] x5, y5;
  assign {cb5, cl5, v5raw, st5, x5, y5} = qtag_unused;

  // Stage 6: S = product of roots (registered).
  logic [TW-1:0]        t6;
  logic signed [XW-1:0] s6, cb6, cl6;
  logic                 v6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5raw;
    if (en) begin
      s6  <= XW'(SW'(rp5) * SW'(rq5)) ^ XW'(unused_tag & 1'b0);
      cb6 <= cb5; cl6 <= cl5;
      t6  <= {1'b0, st5, x5, y5};
    end
  end

  // Three CORDICs in parallel.
  logic signed [AngW-1:0] beta7, link7, base7;
  logic [TW-1:0]          t7;
  logic [0:0]             d1, d2;
  tlik_cordic #(.XW(XW), .ITERS(ANGLE_ITERATIONS), .TAG_W(TW)) u_beta (
    .clk, .rst, .en, .x_in(cb6), .y_in(s6), .tag_in({v6, t6[TW-2:0]}),
    .angle(beta7), .tag_out(t7));
  tlik_cordic #(.XW(XW), .ITERS(ANGLE_ITERATIONS), .TAG_W(1)) u_link (
    .clk, .rst, .en, .x_in(cl6), .y_in(s6), .tag_in(1'b0), .angle(link7),
    .tag_out(d1));
  tlik_cordic #(.XW(XW), .ITERS(ANGLE_ITERATIONS), .TAG_W(1)) u_base (
    .clk, .rst, .en, .x_in(XW'($signed(t6[CoordW +: CoordW]))),
    .y_in(XW'($signed(t6[CoordW-1:0]))),
    .tag_in(1'b0), .angle(base7), .tag_out(d2));

  logic v7;
  logic [1:0] st7;
  assign v7  = t7[TW-1];
  assign st7 = t7[TW-2 -: 2];

  // Stage 8: magnitudes of shoulder and elbow angles.
  localparam int MW = AngW + 1;
  logic           v8, n8, ne8;
  logic [1:0]     st8;
  logic [MW-1:0]  ms8, me8;
  logic signed [MW-1:0] sum7;
  always_comb sum7 = MW'(base7) + MW'(link7) + MW'({d1, d2} & 2'b00);
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
    if (en) begin
      st8 <= st7;
      n8  <= sum7 < 0;
      ne8 <= beta7 < 0;
      ms8 <= (sum7 < 0) ? MW'(-sum7) : MW'(sum7);
      me8 <= (beta7 < 0) ? MW'(-MW'(beta7)) : MW'(beta7);
    end
  end

  // Stage 9: scale by steps per radian.
  localparam int PW = MW + SprW;
  logic          v9, n9, ne9;
  logic [1:0]    st9;
  logic [PW-1:0] ps9, pe9;
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
    if (en) begin
      st9 <= st8; n9 <= n8; ne9 <= ne8;
      ps9 <= PW'(ms8) * PW'(spr);
      pe9 <= PW'(me8) * PW'(spr);
    end
  end

  // Output register; restore the signs after truncating the magnitudes.
  logic [ShW-1:0] sh_q, shm;
  logic [ElW-1:0] el_q, elm;
  logic [1:0]     st_q;
  always_comb begin
    shm = ShW'(ps9 >> 30);
    if (n9) shm = -shm;
    elm = ElW'(pe9 >> 30);
    if (ne9) elm = -elm;
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v9;
    if (en) begin
      st_q <= st9;
      sh_q <= (st9 == ST_SOLVED) ? shm : '0;
      el_q <= (st9 == ST_SOLVED) ? elm : '0;
    end
  end

  // Output handshake: stall whole pipe while result waits untaken.
  assign out_full = out_valid && !joint.ready;
  assign en       = !out_full;

  assign target.ready         = en;
  assign joint.valid          = out_valid;
  assign joint.shoulder_steps = sh_q;
  assign joint.elbow_steps    = el_q;
  assign joint.solve_status   = st_q;
endmodule
`default_nettype wire

// ----- sv/tlik_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined digit-by-digit floor square root: one result bit per stage.
module tlik_isqrt #(
  parameter int W     = 44,
  parameter int TAG_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [W-1:0]     radicand,
  input  wire logic [TAG_W-1:0] tag_in,
  output logic [W/2-1:0]        root,
  output logic [TAG_W-1:0]      tag_out
);
  localparam int N = W / 2;

  logic [W-1:0]     rem [N+1];
  logic [N-1:0]     res [N+1];
  logic [TAG_W-1:0] tag [N+1];

  assign rem[0] = radicand;
  assign res[0] = '0;
  assign tag[0] = tag_in;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int Sh = 2 * (N - 1 - k);
    logic [W+1:0] trial;
    logic         take;
    always_comb begin
      trial = {{2{1'b0}}, rem[k]} - ({{N{1'b0}}, res[k], 2'b01} << Sh);
      take  = !trial[W+1];
    end
    always_ff @(posedge clk) begin
      if (rst) tag[k+1] <= '0;
      else if (en) tag[k+1] <= tag[k];
      if (en) begin
        rem[k+1] <= take ? trial[W-1:0] : rem[k];
        res[k+1] <= {res[k][N-2:0], take};
      end
    end
  end

  assign root    = res[N];
  assign tag_out = tag[N];
endmodule
`default_nettype wire

// ----- sv/tlik_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipelined vectoring CORDIC: a prerotate stage, then one stage per step.
module tlik_cordic #(
  parameter int XW    = 46,
  parameter int ITERS = 16,
  parameter int TAG_W = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic signed [XW-1:0]            x_in,
  input  wire logic signed [XW-1:0]            y_in,
  input  wire logic [TAG_W-1:0]                tag_in,
  output logic signed [tlik_pkg::AngW-1:0]     angle,
  output logic [TAG_W-1:0]                     tag_out
);
  import tlik_pkg::*;

  localparam int N = (ITERS < AtanLen) ? ITERS : AtanLen;
  localparam int IW = XW + 2;

  logic signed [IW-1:0]   xs [N+1];
  logic signed [IW-1:0]   ys [N+1];
  logic signed [AngW-1:0] zs [N+1];
  logic [TAG_W-1:0]       tg [N+1];

  always_ff @(posedge clk) begin
    if (rst) tg[0] <= '0;
    else if (en) tg[0] <= tag_in;
    if (en) begin
      if (x_in < 0) begin
        xs[0] <= -IW'(x_in);
        ys[0] <= -IW'(y_in);
        zs[0] <= (y_in >= 0) ? PiQ30 : -PiQ30;
      end else begin
        xs[0] <= IW'(x_in);
        ys[0] <= IW'(y_in);
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) tg[i+1] <= '0;
      else if (en) tg[i+1] <= tg[i];
      if (en) begin
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_q30(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_q30(i);
        end
      end
    end
  end

  assign angle   = zs[N];
  assign tag_out = tg[N];
endmodule
`default_nettype wire

// ----- sv/tlik_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tlik_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        in_ready,
  input wire logic signed [15:0] shoulder_steps,
  input wire logic [13:0] elbow_steps,
  input wire logic [1:0]  solve_status
);
  import tlik_pkg::*;

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> solve_status == ST_SOLVED || solve_status == ST_REACH ||
                  solve_status == ST_ORIGIN) else $error("bad status");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && solve_status != ST_SOLVED |-> shoulder_steps == 0 && elbow_steps == 0)
    else $error("unsolved result carries steps");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("input taken while stalled");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(elbow_steps))
    else $error("result dropped");
endmodule

bind two_link_inverse_kinematics_core tlik_checker u_chk (
  .clk, .rst, .out_valid(joint.valid), .out_ready(joint.ready),
  .in_ready(target.ready), .shoulder_steps(joint.shoulder_steps),
  .elbow_steps(joint.elbow_steps), .solve_status(joint.solve_status));
`default_nettype wire

// ----- bench/two_link_inverse_kinematics_checker.sv -----
`timescale 1ns / 1ps
module two_link_inverse_kinematics_checker
  import tlik_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tlik_target_if      target,
  tlik_joint_if       joint,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_write_data,
  output int          mismatch_count,
  output int          pending_count
);

  localparam int FracBits   = 8;
  localparam int AngleSteps = 16;
  localparam longint PiRad  = 64'sd3373259426;

  localparam longint ArctanRad [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
    524287, 262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  typedef struct {
    logic signed [ShW-1:0] shoulder;
    logic [ElW-1:0]        elbow;
    solve_status_t         status;
  } joint_pose_t;

  joint_pose_t pose_q[$];

  logic [LinkW-1:0] upper_len;
  logic [LinkW-1:0] lower_len;
  logic [SprW-1:0]  motor_spr;

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC, angle in 2^-30 rad.
  function automatic longint vector_angle(input longint y, input longint x);
    longint ang;
    longint xs;
    longint ys;
    ang = 0;
    if (x < 0) begin
      ang = (y >= 0) ? PiRad : -PiRad;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < AngleSteps && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; ang += ArctanRad[i];
      end else begin
        x -= ys; y += xs; ang -= ArctanRad[i];
      end
    end
    return ang;
  endfunction

  function automatic longint to_steps(input longint ang);
    longint mag;
    longint s;
    mag = (ang < 0) ? -ang : ang;
    s   = (mag * longint'(motor_spr)) >>> 30;
    return (ang < 0) ? -s : s;
  endfunction

  function automatic joint_pose_t solve_pose(input logic signed [CoordW-1:0] tx,
                                             input logic signed [CoordW-1:0] ty);
    joint_pose_t p;
    longint x, y, a, b, rr, dmin, dmax, s, sh, el;
    x = tx;
    y = ty;
    a = longint'(upper_len) << FracBits;
    b = longint'(lower_len) << FracBits;
    rr   = x * x + y * y;
    dmin = (a - b) * (a - b);
    dmax = (a + b) * (a + b);
    sh = 0;
    el = 0;
    if (rr == 0) begin
      p.status = ST_ORIGIN;
    end else if (a == 0 || b == 0 || rr < dmin || rr > dmax) begin
      p.status = ST_REACH;
    end else begin
      p.status = ST_SOLVED;
      s  = longint'(floor_sqrt(rr - dmin) * floor_sqrt(dmax - rr));
      el = to_steps(vector_angle(s, a * a + b * b - rr));
      sh = to_steps(vector_angle(y, x) + vector_angle(s, a * a - b * b + rr));
    end
    p.shoulder = sh[ShW-1:0];
    p.elbow    = el[ElW-1:0];
    return p;
  endfunction

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  always @(posedge clk) begin
    joint_pose_t want;
    if (rst) begin
      upper_len = 8'd75;
      lower_len = 8'd75;
      motor_spr = 12'd326;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          REG_UPPER: upper_len = cfg_write_data[LinkW-1:0];
          REG_LOWER: lower_len = cfg_write_data[LinkW-1:0];
          REG_SPR:   motor_spr = cfg_write_data;
          default: ;
        endcase
      end
      if (target.valid && target.ready)
        pose_q.push_back(solve_pose(target.target_x, target.target_y));
      if (joint.valid && joint.ready) begin
        if (pose_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: joint beat with nothing expected", $time);
        end else begin
          want = pose_q.pop_front();
          if (joint.shoulder_steps !== want.shoulder || joint.elbow_steps !== want.elbow ||
              joint.solve_status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: expected sh=%0d el=%0d st=%0d, got sh=%0d el=%0d st=%0d",
                       $time, want.shoulder, want.elbow, want.status,
                       joint.shoulder_steps, joint.elbow_steps, joint.solve_status);
          end
        end
      end
    end
    pending_count = pose_q.size();
  end

endmodule

// ----- bench/two_link_inverse_kinematics_core_tb.sv -----
`timescale 1ns / 1ps
module two_link_inverse_kinematics_core_tb;
  import tlik_pkg::*;

  // Index 3 is not a register; writes there must be dropped.
  localparam logic [1:0] RegUnused = 2'd3;
  localparam int StallLimit = 2000;
  localparam int DrainWait  = 100;

  logic        clk;
  logic        rst;
  logic        cfg_write_enable;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_write_data;

  int mismatch_count;
  int pending_count;
  int quiet_cycles;

  // Idle percentages for each side, and a long receiver hold-off.
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_cycles;

  // Link lengths as programmed, to aim random targets inside the reach.
  int upper_mm;
  int lower_mm;

  tlik_target_if target_bus ();
  tlik_joint_if  joint_bus ();

  two_link_inverse_kinematics_core DUT (
    .clk              (clk),
    .rst              (rst),
    .target           (target_bus),
    .joint            (joint_bus),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_write_data   (cfg_write_data)
  );

  two_link_inverse_kinematics_checker pose_checker (
    .clk              (clk),
    .rst              (rst),
    .target           (target_bus),
    .joint            (joint_bus),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_write_data   (cfg_write_data),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Receiver: one decision per falling edge; a hold-off request wins.
  always @(negedge clk) begin
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      joint_bus.ready  <= 1'b0;
    end else begin
      joint_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((target_bus.valid && target_bus.ready) || (joint_bus.valid && joint_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("[two_link_inverse_kinematics_core] ERROR");
      $finish;
    end
  end

  // Offer one target beat, idling first at random; hold until accepted.
  task automatic send_target(input int x, input int y);
    while ($urandom_range(99) < send_idle_pct) begin
      target_bus.valid <= 1'b0;
      @(negedge clk);
    end
    target_bus.valid    <= 1'b1;
    target_bus.target_x <= x[CoordW-1:0];
    target_bus.target_y <= y[CoordW-1:0];
    do @(posedge clk); while (!target_bus.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_write_data   <= value[11:0];
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for every expected pose, then let the pipe run dry.
  task automatic drain();
    target_bus.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic set_links(input int upper, input int lower, input int spr);
    write_reg(REG_UPPER, upper);
    write_reg(REG_LOWER, lower);
    write_reg(REG_SPR, spr);
    upper_mm = upper;
    lower_mm = lower;
  endtask

  // Mostly targets within the square around the outer reach circle, some anywhere in range.
  task automatic send_random(input int count);
    int reach;
    int x;
    int y;
    for (int n = 0; n < count; n++) begin
      reach = (upper_mm + lower_mm) << 8;
      if (reach > 131071) reach = 131071;
      if (reach < 1) reach = 1;
      if ($urandom_range(99) < 80) begin
        x = int'($urandom_range(2 * reach)) - reach;
        y = int'($urandom_range(2 * reach)) - reach;
      end else begin
        x = int'($urandom_range(262143)) - 131072;
        y = int'($urandom_range(262143)) - 131072;
      end
      send_target(x, y);
    end
  endtask

  initial begin
    rst              = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_index        = REG_UPPER;
    cfg_write_data   = '0;
    target_bus.valid    = 1'b0;
    target_bus.target_x = '0;
    target_bus.target_y = '0;
    joint_bus.ready     = 1'b0;
    quiet_cycles     = 0;
    recv_hold_cycles = 0;
    send_idle_pct    = 21;
    recv_idle_pct    = 53;
    upper_mm         = 75;
    lower_mm         = 75;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset links: origin, both reach boundaries, the axes, all quadrants,
    // just out of reach and the coordinate extremes.
    send_target(0, 0);
    send_target(38400, 0);
    send_target(-38400, 0);
    send_target(0, 38400);
    send_target(0, -38400);
    send_target(38401, 0);
    send_target(131071, 131071);
    send_target(-131072, -131072);
    send_target(131071, -131072);
    send_target(-131072, 131071);
    send_target(1, 0);
    send_target(0, 1);
    send_target(-1, -1);
    send_target(20000, -15000);
    send_target(-20000, 15000);
    send_target(-20000, -15000);
    send_target(10000, 10000);
    send_target(-38400, -1);

    // Stall the receiver while targets keep coming so the pipe backs up.
    recv_hold_cycles = 400;
    send_random(150);
    drain();

    set_links(255, 255, 4095);
    send_target(130560, 0);
    send_target(-130560, 0);
    send_target(0, -130560);
    send_random(160);
    drain();

    send_idle_pct = 53;
    recv_idle_pct = 21;
    // Unequal links open a hole around the base.
    set_links(200, 50, 326);
    send_target(38400, 0);
    send_target(38399, 0);
    send_target(0, -38400);
    send_random(160);
    drain();

    set_links(1, 1, 1);
    send_random(160);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_links(0, 75, 326);
    write_reg(RegUnused, 12'hFFF);
    send_target(100, 100);
    send_random(120);
    drain();

    set_links(75, 75, 0);
    send_target(20000, 20000);
    send_random(160);
    drain();

    if (mismatch_count == 0 && pending_count == 0)
      $display("[two_link_inverse_kinematics_core] OK");
    else
      $display("[two_link_inverse_kinematics_core] ERROR");
    $finish;
  end

endmodule
